>>> sv/asldc_pkg.sv
// Package for the armed slew-limited drive command block.
// Holds word types, fixed-point constants and register addresses; no dependencies.
package asldc_pkg;

    localparam int unsigned CMD_W     = 15;  // unsigned command width
    localparam int unsigned STEER_W   = 16;  // signed steering width
    localparam int unsigned RATE_W    = 12;  // Q4.8 rate width
    localparam int unsigned DT_IN_W   = 16;  // raw elapsed width
    localparam int unsigned DT_W      = 13;  // saturated elapsed width
    localparam int unsigned PROD_W    = RATE_W + DT_W;
    localparam int unsigned STEP_SH   = 10;
    localparam int unsigned STEP_W    = PROD_W - STEP_SH;
    localparam int unsigned ACC_W     = 18;  // signed working width of the ramps
    localparam int unsigned PADDR_W   = 5;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [CMD_W-1:0]   FULL_SCALE  = CMD_W'(16384);
    localparam logic [DT_W-1:0]    ELAPSED_MAX = DT_W'(6554);
    localparam logic [RATE_W-1:0]  BRAKE_RELEASE_RATE = RATE_W'(1792);

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_THR_LIMIT  = 3'd0;
    localparam logic [2:0] REG_BRK_LIMIT  = 3'd1;
    localparam logic [2:0] REG_STEER_LIM  = 3'd2;
    localparam logic [2:0] REG_THR_RISE   = 3'd3;
    localparam logic [2:0] REG_THR_FALL   = 3'd4;
    localparam logic [2:0] REG_BRK_RISE   = 3'd5;
    localparam logic [2:0] REG_STEER_RATE = 3'd6;
    localparam logic [2:0] REG_STEER_RET  = 3'd7;

    // register reset values
    localparam logic [CMD_W-1:0]  RST_THR_LIMIT  = CMD_W'(16384);
    localparam logic [CMD_W-1:0]  RST_BRK_LIMIT  = CMD_W'(16384);
    localparam logic [CMD_W-1:0]  RST_STEER_LIM  = CMD_W'(16384);
    localparam logic [RATE_W-1:0] RST_THR_RISE   = RATE_W'(384);
    localparam logic [RATE_W-1:0] RST_THR_FALL   = RATE_W'(768);
    localparam logic [RATE_W-1:0] RST_BRK_RISE   = RATE_W'(1280);
    localparam logic [RATE_W-1:0] RST_STEER_RATE = RATE_W'(640);
    localparam logic [RATE_W-1:0] RST_STEER_RET  = RATE_W'(1024);

    typedef struct packed {
        logic               accel_pressed;
        logic               slow_pressed;
        logic               left_pressed;
        logic               right_pressed;
        logic               emergency_pressed;
        logic               arm_pressed;
        logic               quit_pressed;
        logic [DT_IN_W-1:0] elapsed;
    } t_in_word;

    typedef struct packed {
        logic [CMD_W-1:0]          throttle_out;
        logic [CMD_W-1:0]          brake_out;
        logic signed [STEER_W-1:0] steer_out;
        logic                      armed_out;
        logic                      exit_out;
    } t_out_word;

endpackage

>>> sv/asldc_in_if.sv
// Input channel carrying one control tick word.
// Depends on asldc_pkg.
interface asldc_in_if import asldc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/asldc_out_if.sv
// Output channel carrying one drive command word.
// Depends on asldc_pkg.
interface asldc_out_if import asldc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/armed_slew_limited_drive_command.sv
// Armed slew-limited drive command: an accepted word goes into the input register, then into the
// level state, which is the result word; throughput one word per cycle while the result side takes words.
// Stage 1 is the input register; stage 2 is the level state, which is the result word.
// Reset (i_rst_n low, synchronous) disarms, clears exit, sets throttle 0,
// brake full, steering centre, and restores every register to its default.
// Depends on asldc_pkg, asldc_in_if, asldc_out_if.
module armed_slew_limited_drive_command
    import asldc_pkg::*;
#(
    parameter logic [RATE_W-1:0] RELEASE_RATE = BRAKE_RELEASE_RATE
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    asldc_in_if.sink           i_cmd,
    asldc_out_if.source        o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // ---------------------------------------------------------------------
    // Register file
    // ---------------------------------------------------------------------
    logic [CMD_W-1:0]  r_thr_limit, r_brk_limit, r_steer_lim;
    logic [RATE_W-1:0] r_thr_rise, r_thr_fall, r_brk_rise, r_steer_rate, r_steer_ret;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_limit  <= RST_THR_LIMIT;
            r_brk_limit  <= RST_BRK_LIMIT;
            r_steer_lim  <= RST_STEER_LIM;
            r_thr_rise   <= RST_THR_RISE;
            r_thr_fall   <= RST_THR_FALL;
            r_brk_rise   <= RST_BRK_RISE;
            r_steer_rate <= RST_STEER_RATE;
            r_steer_ret  <= RST_STEER_RET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_THR_LIMIT:  r_thr_limit  <= pwdata[CMD_W-1:0];
                REG_BRK_LIMIT:  r_brk_limit  <= pwdata[CMD_W-1:0];
                REG_STEER_LIM:  r_steer_lim  <= pwdata[CMD_W-1:0];
                REG_THR_RISE:   r_thr_rise   <= pwdata[RATE_W-1:0];
                REG_THR_FALL:   r_thr_fall   <= pwdata[RATE_W-1:0];
                REG_BRK_RISE:   r_brk_rise   <= pwdata[RATE_W-1:0];
                REG_STEER_RATE: r_steer_rate <= pwdata[RATE_W-1:0];
                REG_STEER_RET:  r_steer_ret  <= pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_THR_LIMIT:  prdata = PDATA_W'(r_thr_limit);
            REG_BRK_LIMIT:  prdata = PDATA_W'(r_brk_limit);
            REG_STEER_LIM:  prdata = PDATA_W'(r_steer_lim);
            REG_THR_RISE:   prdata = PDATA_W'(r_thr_rise);
            REG_THR_FALL:   prdata = PDATA_W'(r_thr_fall);
            REG_BRK_RISE:   prdata = PDATA_W'(r_brk_rise);
            REG_STEER_RATE: prdata = PDATA_W'(r_steer_rate);
            REG_STEER_RET:  prdata = PDATA_W'(r_steer_ret);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Handshake: stage 1 holds an accepted word; it moves into the level
    // state whenever the result stage is empty or its word is being taken.
    // ---------------------------------------------------------------------
    logic     r_in_valid, r_out_valid;
    t_in_word r_in;
    logic     advance, fire;

    assign advance     = !r_out_valid || o_res.ready;
    assign fire        = r_in_valid && advance;
    assign i_cmd.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ready) r_in_valid <= i_cmd.valid;
            if (advance)     r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) r_in <= i_cmd.data;
    end

    // ---------------------------------------------------------------------
    // Ramp helpers
    // ---------------------------------------------------------------------
    function automatic logic [CMD_W-1:0] limit_of(input logic [CMD_W-1:0] raw);
        return (raw > FULL_SCALE) ? FULL_SCALE : raw;
    endfunction

    // step = (rate * dt) >> 10, one 12x13 multiply per ramp
    function automatic logic [STEP_W-1:0] step_of(input logic [RATE_W-1:0] rate,
                                                  input logic [DT_W-1:0] dt);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(rate) * PROD_W'(dt);
        return prod[PROD_W-1:STEP_SH];
    endfunction

    // move cur toward tgt by at most d, never overshooting
    function automatic logic signed [ACC_W-1:0] approach(input logic signed [ACC_W-1:0] cur,
                                                         input logic signed [ACC_W-1:0] tgt,
                                                         input logic [STEP_W-1:0] d);
        logic signed [ACC_W-1:0] ds, v;
        ds = $signed(ACC_W'(d));
        if (cur < tgt) begin
            v = cur + ds;
            return (v < tgt) ? v : tgt;
        end else begin
            v = cur - ds;
            return (v > tgt) ? v : tgt;
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] from_u(input logic [CMD_W-1:0] x);
        return $signed(ACC_W'(x));
    endfunction

    // ---------------------------------------------------------------------
    // Control state and levels
    // ---------------------------------------------------------------------
    logic                      r_armed, r_arm_prev, r_quit_prev, r_exit;
    logic [CMD_W-1:0]          r_thr, r_brk;
    logic signed [STEER_W-1:0] r_steer;

    logic                      n_armed, n_exit;
    logic [CMD_W-1:0]          n_thr, n_brk;
    logic signed [STEER_W-1:0] n_steer;

    logic                      arm_edge, quit_edge, armed_tog, active, braking, steer_side;
    logic [DT_W-1:0]           dt;
    logic [CMD_W-1:0]          thr_base, brk_base, steer_mag;
    logic [RATE_W-1:0]         thr_rate, brk_rate, st_rate;
    logic signed [ACC_W-1:0]   thr_tgt, brk_tgt, st_tgt, thr_new, brk_new, st_new;

    always_comb begin
        // elapsed saturates at about 0.1 s
        dt = (r_in.elapsed > DT_IN_W'(ELAPSED_MAX)) ? ELAPSED_MAX : r_in.elapsed[DT_W-1:0];

        // arm edge toggles first and resets throttle and brake; quit then disarms
        arm_edge  = r_in.arm_pressed && !r_arm_prev;
        quit_edge = r_in.quit_pressed && !r_quit_prev;
        armed_tog = r_armed ^ arm_edge;
        thr_base  = arm_edge ? '0 : r_thr;
        brk_base  = arm_edge ? (armed_tog ? '0 : FULL_SCALE) : r_brk;
        n_armed   = armed_tog && !quit_edge;
        n_exit    = r_exit || quit_edge;
        active    = n_armed && !n_exit;

        // throttle: rise toward limit only while accel held and no braking
        braking  = r_in.emergency_pressed || r_in.slow_pressed;
        if (!braking && r_in.accel_pressed) begin
            thr_tgt  = from_u(limit_of(r_thr_limit));
            thr_rate = r_thr_rise;
        end else begin
            thr_tgt  = '0;
            thr_rate = r_thr_fall;
        end
        thr_new = approach(from_u(thr_base), thr_tgt, step_of(thr_rate, dt));

        // brake: held button ramps up to its limit, otherwise release
        if (r_in.slow_pressed) begin
            brk_tgt  = from_u(limit_of(r_brk_limit));
            brk_rate = r_brk_rise;
        end else begin
            brk_tgt  = '0;
            brk_rate = RELEASE_RATE;
        end
        brk_new = approach(from_u(brk_base), brk_tgt, step_of(brk_rate, dt));

        // steering: a single side held (armed, not exited, nonzero limit) targets that side, else centre
        steer_mag  = limit_of(r_steer_lim);
        steer_side = active && (r_in.left_pressed != r_in.right_pressed)
                     && (steer_mag != '0);
        if (steer_side) begin
            st_tgt  = r_in.left_pressed ? -from_u(steer_mag) : from_u(steer_mag);
            st_rate = r_steer_rate;
        end else begin
            st_tgt  = '0;
            st_rate = r_steer_ret;
        end
        st_new = approach(ACC_W'(r_steer), st_tgt, step_of(st_rate, dt));

        if (!active) begin
            n_thr = '0;
            n_brk = FULL_SCALE;
        end else begin
            n_thr = thr_new[CMD_W-1:0];
            n_brk = r_in.emergency_pressed ? FULL_SCALE : brk_new[CMD_W-1:0];
        end
        n_steer = st_new[STEER_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_arm_prev  <= 1'b0;
            r_quit_prev <= 1'b0;
            r_exit      <= 1'b0;
            r_thr       <= '0;
            r_brk       <= FULL_SCALE;
            r_steer     <= '0;
        end else if (fire) begin
            r_armed     <= n_armed;
            r_arm_prev  <= r_in.arm_pressed;
            r_quit_prev <= r_in.quit_pressed;
            r_exit      <= n_exit;
            r_thr       <= n_thr;
            r_brk       <= n_brk;
            r_steer     <= n_steer;
        end
    end

    // levels stay in range, so the state itself is the result word
    assign o_res.valid             = r_out_valid;
    assign o_res.data.throttle_out = r_thr;
    assign o_res.data.brake_out    = r_brk;
    assign o_res.data.steer_out    = r_steer;
    assign o_res.data.armed_out    = r_armed;
    assign o_res.data.exit_out     = r_exit;

endmodule
